[sv/number_overlay_run_rectangles_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the FPS overlay rectangle generator
// Compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef NUMBER_OVERLAY_RUN_RECTANGLES_CORE_MACROS_SVH
`define NUMBER_OVERLAY_RUN_RECTANGLES_CORE_MACROS_SVH

`ifndef SYNTH
// expr holds at every edge out of reset
`define NOVR_ASSERT_HOLDS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("overlay check failed");
// cons holds at every edge where ante holds
`define NOVR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("overlay check failed");
`else
`define NOVR_ASSERT_HOLDS(lbl, expr)
`define NOVR_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

[sv/novr_pkg.sv]
// ---------------------------------------------------------------------------
// novr_pkg
// Shared types, layout constants and the 5x7 font for the FPS overlay.
// ---------------------------------------------------------------------------
package novr_pkg;

	localparam int PIXEL_SCALE = 2;
	localparam int COORD_W     = 12;
	localparam int YPOS_W      = 6;
	localparam int TEXT_MARGIN = 10;
	localparam int FONT_W      = 5;
	localparam int FONT_H      = 7;
	localparam int GLYPH_ADV   = 6 * PIXEL_SCALE;
	localparam int GLYPH_H     = 7 * PIXEL_SCALE;
	localparam int BACK_PAD_X  = 5;
	localparam int BACK_PAD_Y  = 4;
	localparam int RATE_MAX    = 999;

	localparam logic [COORD_W-1:0] SCREEN_WIDTH_RESET = 12'd640;

	// register index (byte address bit 2)
	localparam logic REG_SCREEN_WIDTH = 1'b0;

	// glyph codes for the letters; digits use their own value
	localparam logic [3:0] GLYPH_F = 4'd10;
	localparam logic [3:0] GLYPH_P = 4'd11;
	localparam logic [3:0] GLYPH_S = 4'd12;

	localparam logic FILL_BACKDROP = 1'b0;
	localparam logic FILL_GLYPH    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HUND,
		ST_TENS,
		ST_PLACE,
		ST_BACK,
		ST_RUNS
	} seq_state_t;

	// one horizontal run inside a font row
	typedef struct packed {
		logic       found;
		logic [2:0] start;
		logic [2:0] len;
		logic [2:0] next_col;
		logic       more;
	} run_info_t;

	localparam logic [4:0] FONT_ROWS [0:12][0:6] = '{
		'{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
		'{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
		'{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
		'{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
		'{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
		'{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		'{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
		'{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}
	};

	function automatic logic [4:0] font_row(input logic [3:0] code, input logic [2:0] row);
		logic [4:0] bits;
		bits = '0;
		if (code <= GLYPH_S && row <= 3'(FONT_H - 1)) begin
			bits = FONT_ROWS[code][row];
		end
		return bits;
	endfunction

endpackage

[sv/novr_run_find.sv]
// ---------------------------------------------------------------------------
// novr_run_find
// Finds the next run of set pixels in a font row at or after a column.
// ---------------------------------------------------------------------------
module novr_run_find (
	input  logic [4:0]           row_bits,
	input  logic [2:0]           start_col,
	output novr_pkg::run_info_t  run
);
	import novr_pkg::*;

	logic       found;
	logic       ended;
	logic       more;
	logic [2:0] st;
	logic [2:0] ln;
	logic [2:0] nxt;

	// column c maps to bit 4-c (leftmost pixel is the MSB)
	always_comb begin
		found = 1'b0;
		st    = '0;
		for (int i = 0; i < FONT_W; i++) begin
			if (!found && (3'(i) >= start_col) && row_bits[FONT_W-1-i]) begin
				found = 1'b1;
				st    = 3'(i);
			end
		end
		ended = 1'b0;
		ln    = '0;
		for (int i = 0; i < FONT_W; i++) begin
			if (found && (3'(i) >= st) && !ended) begin
				if (row_bits[FONT_W-1-i]) begin
					ln = ln + 3'd1;
				end else begin
					ended = 1'b1;
				end
			end
		end
		nxt  = st + ln;
		more = 1'b0;
		for (int i = 0; i < FONT_W; i++) begin
			if ((3'(i) >= nxt) && row_bits[FONT_W-1-i]) begin
				more = 1'b1;
			end
		end
	end

	always_comb begin
		run.found    = found;
		run.start    = st;
		run.len      = ln;
		run.next_col = nxt;
		run.more     = more;
	end

endmodule

[sv/number_overlay_run_rectangles_core.sv]
// ---------------------------------------------------------------------------
// number_overlay_run_rectangles_core: "<n> FPS" overlay rectangle generator
// First beat (backdrop) follows ST_HUND, ST_TENS and ST_PLACE after accept.
// Per number: the 10-bit subtract/compare unit walks the digits, then one
//   rectangle per cycle while rect_stall is low (the space slot gives none).
// Reset: idle, no output beat, screen_width back to 640.
// ---------------------------------------------------------------------------
`include "number_overlay_run_rectangles_core_macros.svh"

module number_overlay_run_rectangles_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB-style config port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// number in
	input  logic                            rate_valid,
	output logic                            rate_stall,
	input  logic signed [15:0]              rate_value,
	// rectangles out
	output logic                            rect_valid,
	input  logic                            rect_stall,
	output logic [novr_pkg::COORD_W-1:0]    left_x,
	output logic [novr_pkg::YPOS_W-1:0]     top_y,
	output logic [novr_pkg::COORD_W-1:0]    right_x,
	output logic [novr_pkg::YPOS_W-1:0]     bottom_y,
	output logic                            fill_kind,
	output logic                            last_rect
);
	import novr_pkg::*;

	// ---------------- config register ----------------
	logic [COORD_W-1:0] sw_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCREEN_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SCREEN_WIDTH_RESET;
		end else if (cfg_wr) begin
			sw_q <= pwdata[COORD_W-1:0];
		end
	end

	// beyond the list reads as zero
	assign prdata = (paddr[2] == REG_SCREEN_WIDTH) ? {{(32-COORD_W){1'b0}}, sw_q} : '0;

	// ---------------- sequencer state ----------------
	seq_state_t         state_q, state_d;
	logic [9:0]         rem_q;
	logic [3:0]         hund_q, tens_q;
	logic [1:0]         ndig_q;
	logic [3:0]         dig_q [3];
	logic [COORD_W-1:0] x0_q, gx_q;
	logic [2:0]         slot_q, row_q, col_q;

	// output register
	logic               rect_valid_q;
	logic [COORD_W-1:0] left_x_q, right_x_q;
	logic [YPOS_W-1:0]  top_y_q, bottom_y_q;
	logic               fill_kind_q, last_rect_q;

	// ---------------- shared subtract/compare unit ----------------
	// Digit split by repeated subtraction: by 100 in ST_HUND, by 10 in ST_TENS.
	logic [9:0]  sub_op;
	logic [10:0] sub_diff;
	logic        sub_ge;

	assign sub_op   = (state_q == ST_HUND) ? 10'd100 : 10'd10;
	assign sub_diff = {1'b0, rem_q} - {1'b0, sub_op};
	assign sub_ge   = !sub_diff[10];

	// clamp to 0..999 on the way in
	logic [9:0] clamp_val;
	always_comb begin
		priority if (rate_value[15]) begin
			clamp_val = '0;
		end else if (rate_value > 16'(RATE_MAX)) begin
			clamp_val = 10'(RATE_MAX);
		end else begin
			clamp_val = rate_value[9:0];
		end
	end

	// ---------------- layout (ST_PLACE) ----------------
	// No leading zeros; digits left-packed into dig slots.
	logic [1:0]         n_dig;
	logic [3:0]         d_new [3];
	logic [2:0]         n_glyph;
	logic [COORD_W-1:0] text_w;
	logic [COORD_W-1:0] x0_new;

	always_comb begin
		priority if (hund_q != 4'd0) begin
			n_dig    = 2'd3;
			d_new[0] = hund_q;
			d_new[1] = tens_q;
			d_new[2] = rem_q[3:0];
		end else if (tens_q != 4'd0) begin
			n_dig    = 2'd2;
			d_new[0] = tens_q;
			d_new[1] = rem_q[3:0];
			d_new[2] = '0;
		end else begin
			n_dig    = 2'd1;
			d_new[0] = rem_q[3:0];
			d_new[1] = '0;
			d_new[2] = '0;
		end
		// digits + space + F P S
		n_glyph = {1'b0, n_dig} + 3'd4;
		text_w  = 12'(n_glyph) * 12'(GLYPH_ADV) - 12'(PIXEL_SCALE);
		// edges wrap modulo 4096 on narrow screens
		x0_new  = sw_q - text_w - 12'(TEXT_MARGIN);
	end

	// ---------------- glyph walk (ST_RUNS) ----------------
	// slots: digits, space, F, P, S
	logic       is_space;
	logic       last_slot;
	logic       row_last;
	logic       is_last;
	logic [3:0] code;
	logic [4:0] row_bits;
	run_info_t  run;

	always_comb begin
		is_space  = (slot_q == {1'b0, ndig_q});
		last_slot = (slot_q == ({1'b0, ndig_q} + 3'd3));
		row_last  = (row_q == 3'(FONT_H - 1));
		if (slot_q < {1'b0, ndig_q}) begin
			code = dig_q[slot_q[1:0]];
		end else begin
			code = GLYPH_F + 4'(slot_q - {1'b0, ndig_q} - 3'd1);
		end
		row_bits = font_row(code, row_q);
	end

	novr_run_find u_run_find (
		.row_bits  (row_bits),
		.start_col (col_q),
		.run       (run)
	);

	// every font row has a set pixel, so each run-state cycle outside the space slot yields a beat unless stalled
	assign is_last = last_slot && row_last && !run.more;

	// ---------------- sequencer control ----------------
	logic can_load;
	logic emit_back;
	logic emit_run;
	logic step_glyph;

	// output register is free or being drained this cycle
	assign can_load = !rect_valid_q || !rect_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rate_valid) begin
					state_d = ST_HUND;
				end
			end
			ST_HUND: begin
				if (!sub_ge) begin
					state_d = ST_TENS;
				end
			end
			ST_TENS: begin
				if (!sub_ge) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				state_d = ST_BACK;
			end
			ST_BACK: begin
				if (can_load) begin
					state_d = ST_RUNS;
				end
			end
			ST_RUNS: begin
				if (!is_space && can_load && is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rate_stall = (state_q != ST_IDLE);
		emit_back  = (state_q == ST_BACK) && can_load;
		emit_run   = (state_q == ST_RUNS) && !is_space && can_load;
		// space slot is skipped with no beat
		step_glyph = (state_q == ST_RUNS) &&
			(is_space || (emit_run && !run.more && row_last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (rate_valid) begin
					rem_q  <= clamp_val;
					hund_q <= '0;
					tens_q <= '0;
				end
			end
			ST_HUND: begin
				if (sub_ge) begin
					rem_q  <= sub_diff[9:0];
					hund_q <= hund_q + 4'd1;
				end
			end
			ST_TENS: begin
				if (sub_ge) begin
					rem_q  <= sub_diff[9:0];
					tens_q <= tens_q + 4'd1;
				end
			end
			ST_PLACE: begin
				ndig_q <= n_dig;
				dig_q  <= d_new;
				x0_q   <= x0_new;
				gx_q   <= x0_new;
				slot_q <= '0;
				row_q  <= '0;
				col_q  <= '0;
			end
			ST_BACK: begin
			end
			ST_RUNS: begin
				if (step_glyph) begin
					slot_q <= slot_q + 3'd1;
					gx_q   <= gx_q + 12'(GLYPH_ADV);
					row_q  <= '0;
					col_q  <= '0;
				end else if (emit_run) begin
					if (run.more) begin
						col_q <= run.next_col;
					end else begin
						col_q <= '0;
						row_q <= row_q + 3'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------- output register ----------------
	logic [COORD_W-1:0] run_px;
	logic [YPOS_W-1:0]  run_py;

	assign run_px = gx_q + 12'(run.start) * 12'(PIXEL_SCALE);
	assign run_py = 6'(TEXT_MARGIN) + 6'(row_q) * 6'(PIXEL_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_valid_q <= 1'b0;
		end else if (emit_back || emit_run) begin
			rect_valid_q <= 1'b1;
		end else if (!rect_stall) begin
			rect_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_back) begin
			// backdrop right edge: x0 + text width + pad = screen - margin + pad
			left_x_q    <= x0_q - 12'(BACK_PAD_X);
			top_y_q     <= 6'(TEXT_MARGIN - BACK_PAD_Y);
			right_x_q   <= sw_q - 12'(TEXT_MARGIN - BACK_PAD_X);
			bottom_y_q  <= 6'(TEXT_MARGIN + GLYPH_H + BACK_PAD_Y);
			fill_kind_q <= FILL_BACKDROP;
			last_rect_q <= 1'b0;
		end else if (emit_run) begin
			left_x_q    <= run_px;
			top_y_q     <= run_py;
			right_x_q   <= run_px + 12'(run.len) * 12'(PIXEL_SCALE);
			bottom_y_q  <= run_py + 6'(PIXEL_SCALE);
			fill_kind_q <= FILL_GLYPH;
			last_rect_q <= is_last;
		end
	end

	assign rect_valid = rect_valid_q;
	assign left_x     = left_x_q;
	assign top_y      = top_y_q;
	assign right_x    = right_x_q;
	assign bottom_y   = bottom_y_q;
	assign fill_kind  = fill_kind_q;
	assign last_rect  = last_rect_q;

	// ---------------- checks ----------------
	// hundreds count never passes 9 after the clamp
	`NOVR_ASSERT_IMPL(a_hund_digit, state_q == ST_TENS, hund_q <= 4'd9)
	// run scan stays inside the 5-pixel font row
	`NOVR_ASSERT_IMPL(a_col_range, state_q == ST_RUNS, col_q <= 3'd4)
	// a final beat on the port means the glyph walk has ended
	`NOVR_ASSERT_IMPL(a_last_ends_walk, rect_valid && last_rect, state_q != ST_RUNS)

endmodule
